FILE: hdl/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// Types and constants shared by the resource record stream parser modules.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_RESNUM  = 3'd3,
        PH_LANG    = 3'd4,
        PH_TEXT    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MAGIC   = 3'd1,
        ERR_VERSION = 3'd2,
        ERR_COUNT   = 3'd3,
        ERR_LONG    = 3'd4,
        ERR_TRUNC   = 3'd5
    } t_err;

    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] CFG_MAX_TEXT_BYTES   = 2'd1;

    localparam logic [31:0] EXPECTED_VERSION_RESET = 32'd5;
    localparam logic [15:0] MAX_TEXT_BYTES_RESET   = 16'd20000;

    localparam logic       KIND_TEXT   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] resource_number;
        logic signed [31:0] language_id;
        logic [7:0]         text_byte;
        logic               end_of_text;
        logic               file_complete;
        t_err               error_code;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h52;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h43;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/rrsp_core.sv
// ----------------------------------------------------------------------------
// rrsp_core
// Parser state, configuration registers and combinational byte step logic.
// ----------------------------------------------------------------------------
module rrsp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_file,
    input  logic              i_end_of_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_res_valid,
    output rrsp_pkg::t_result o_res
);
    import rrsp_pkg::*;

    logic [31:0] r_expected_version;
    logic [15:0] r_max_text_bytes;

    t_phase      r_phase,  n_phase,  s_phase;
    logic [1:0]  r_bif,    n_bif,    s_bif;
    logic [31:0] r_shift,  n_shift,  s_shift;
    logic [31:0] r_res,    n_res,    s_res;
    logic [31:0] r_lang,   n_lang,   s_lang;
    logic [30:0] r_left,   n_left,   s_left;
    logic [15:0] r_tlen,   n_tlen,   s_tlen;
    logic        r_stop,   n_stop,   s_stop;

    logic [15:0] limit;
    logic [30:0] left_dec;
    logic        word_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= EXPECTED_VERSION_RESET;
            r_max_text_bytes   <= MAX_TEXT_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_expected_version <= i_cfg_data;
                CFG_MAX_TEXT_BYTES:   r_max_text_bytes   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_start_of_file) begin
            s_phase = PH_MAGIC;
            s_bif   = '0;
            s_shift = '0;
            s_res   = '0;
            s_lang  = '0;
            s_left  = '0;
            s_tlen  = '0;
            s_stop  = 1'b0;
        end else begin
            s_phase = r_phase;
            s_bif   = r_bif;
            s_shift = r_shift;
            s_res   = r_res;
            s_lang  = r_lang;
            s_left  = r_left;
            s_tlen  = r_tlen;
            s_stop  = r_stop;
        end
    end

    assign limit    = r_max_text_bytes - 16'd1;
    assign left_dec = s_left - 31'd1;

    always_comb begin
        n_phase     = s_phase;
        n_bif       = s_bif;
        n_shift     = s_shift;
        n_res       = s_res;
        n_lang      = s_lang;
        n_left      = s_left;
        n_tlen      = s_tlen;
        n_stop      = s_stop;
        word_done   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!s_stop) begin
            case (s_phase)
                PH_MAGIC: begin
                    if (i_data_byte != magic_byte(s_bif)) begin
                        n_stop                 = 1'b1;
                        o_res_valid            = 1'b1;
                        o_res.result_kind      = KIND_STATUS;
                        o_res.error_code       = ERR_MAGIC;
                    end else begin
                        n_bif = s_bif + 2'd1;
                        if (s_bif == 2'd3) begin
                            n_phase = PH_VERSION;
                        end
                    end
                end
                PH_TEXT: begin
                    if (s_tlen == limit) begin
                        n_stop            = 1'b1;
                        o_res_valid       = 1'b1;
                        o_res.result_kind = KIND_STATUS;
                        o_res.error_code  = ERR_LONG;
                    end else begin
                        o_res_valid           = 1'b1;
                        o_res.result_kind     = KIND_TEXT;
                        o_res.resource_number = s_res;
                        o_res.language_id     = s_lang;
                        o_res.text_byte       = i_data_byte;
                        o_res.end_of_text     = (i_data_byte == 8'd0);
                        if (i_data_byte == 8'd0) begin
                            n_left = left_dec;
                            n_tlen = '0;
                            if (left_dec == '0) begin
                                n_stop              = 1'b1;
                                o_res.file_complete = 1'b1;
                            end else begin
                                n_phase = PH_RESNUM;
                            end
                        end else begin
                            n_tlen = s_tlen + 16'd1;
                        end
                    end
                end
                default: begin
                    n_shift   = {i_data_byte, s_shift[31:8]};
                    n_bif     = s_bif + 2'd1;
                    word_done = (s_bif == 2'd3);
                end
            endcase

            if (word_done) begin
                case (s_phase)
                    PH_VERSION: begin
                        if (n_shift != r_expected_version) begin
                            n_stop            = 1'b1;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_STATUS;
                            o_res.error_code  = ERR_VERSION;
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        if (n_shift[31]) begin
                            n_stop            = 1'b1;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_STATUS;
                            o_res.error_code  = ERR_COUNT;
                        end else begin
                            n_left = n_shift[30:0];
                            if (n_shift[30:0] == '0) begin
                                n_stop              = 1'b1;
                                o_res_valid         = 1'b1;
                                o_res.result_kind   = KIND_STATUS;
                                o_res.file_complete = 1'b1;
                            end else begin
                                n_phase = PH_RESNUM;
                            end
                        end
                    end
                    PH_RESNUM: begin
                        n_res   = n_shift;
                        n_phase = PH_LANG;
                    end
                    default: begin
                        n_lang  = n_shift;
                        n_tlen  = '0;
                        n_phase = PH_TEXT;
                    end
                endcase
            end

            if (i_end_of_data && !n_stop) begin
                n_stop            = 1'b1;
                o_res_valid       = 1'b1;
                o_res             = '0;
                o_res.result_kind = KIND_STATUS;
                o_res.error_code  = ERR_TRUNC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_bif   <= '0;
            r_shift <= '0;
            r_res   <= '0;
            r_lang  <= '0;
            r_left  <= '0;
            r_tlen  <= '0;
            r_stop  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_shift <= n_shift;
            r_res   <= n_res;
            r_lang  <= n_lang;
            r_left  <= n_left;
            r_tlen  <= n_tlen;
            r_stop  <= n_stop;
        end
    end

endmodule

FILE: hdl/rrsp_out_buf.sv
// ----------------------------------------------------------------------------
// rrsp_out_buf
// Two-entry result queue that decouples the parser from output stall.
// ----------------------------------------------------------------------------
module rrsp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rrsp_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output rrsp_pkg::t_result o_data
);
    import rrsp_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_ok;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_slot[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/resource_record_stream_parser.sv
// ----------------------------------------------------------------------------
// resource_record_stream_parser
// Byte-stream parser for resource files: header check and tagged text output.
// ----------------------------------------------------------------------------
// The parser takes one file byte per clock cycle and produces at most one
// result per byte. Each byte is handled by a combinational update of the
// header and record state, so the input rate is one byte per cycle; a
// two-entry result queue holds results while the output stalls, and the
// input stalls only when that queue is full. Configuration writes are
// always ready and take effect on the next byte.
module resource_record_stream_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_start_of_file,
    input  logic               i_end_of_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_result_kind,
    output logic signed [31:0] o_resource_number,
    output logic signed [31:0] o_language_id,
    output logic [7:0]         o_text_byte,
    output logic               o_end_of_text,
    output logic               o_file_complete,
    output logic [2:0]         o_error_code,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rrsp_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    logic    q_full;
    t_result q_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    rrsp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_end_of_data   (i_end_of_data),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    rrsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && res_valid),
        .i_data  (res),
        .i_pop   (!i_out_stall),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .o_data  (q_data)
    );

    assign o_result_kind     = q_data.result_kind;
    assign o_resource_number = q_data.resource_number;
    assign o_language_id     = q_data.language_id;
    assign o_text_byte       = q_data.text_byte;
    assign o_end_of_text     = q_data.end_of_text;
    assign o_file_complete   = q_data.file_complete;
    assign o_error_code      = q_data.error_code;

    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_result_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid) |=> o_out_valid)
        else $error("accepted result not presented");

    a_status_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_STATUS) |->
        (o_text_byte == 8'd0 && !o_end_of_text && o_resource_number == 32'sd0))
        else $error("status report carries text fields");

    a_text_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_TEXT) |->
        (o_error_code == ERR_NONE && (o_file_complete == 1'b0 || o_end_of_text)))
        else $error("text result carries error or early completion");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the resource record stream parser.
// ----------------------------------------------------------------------------
// Feeds resource files one byte per transaction through the input channel,
// directed cases first and then random well-formed and broken files. A
// scoreboard holds its own copy of the parser state and configuration,
// predicts the result of every accepted byte and checks each accepted output
// transaction field by field. The run goes through four random phases, each
// with its own register settings and input idle and output stall mix, with a
// long output hold-off and a full drain along the way.
// ----------------------------------------------------------------------------
module tb_top;
    import rrsp_pkg::*;

    localparam logic [31:0] SIGNATURE_WORD = 32'h0143_5352;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASE_BYTES    = 170;
    localparam int          HOLD_CYCLES    = 300;

    class rrsp_scoreboard;
        logic [31:0] want_version;
        logic [15:0] text_cap;
        t_phase      stage;
        logic [1:0]  byte_pos;
        logic [31:0] shift_word;
        logic [31:0] cur_resource;
        logic [31:0] cur_language;
        logic [30:0] records_left;
        logic [15:0] text_len;
        bit          halted;
        t_result     awaited_results[$];
        int          failures;
        int          live_bytes;

        function new();
            want_version = EXPECTED_VERSION_RESET;
            text_cap     = MAX_TEXT_BYTES_RESET;
            failures     = 0;
            live_bytes   = 0;
            restart();
        endfunction

        function void restart();
            stage        = PH_MAGIC;
            byte_pos     = 2'd0;
            shift_word   = 32'd0;
            cur_resource = 32'd0;
            cur_language = 32'd0;
            records_left = 31'd0;
            text_len     = 16'd0;
            halted       = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            if (idx == CFG_EXPECTED_VERSION) begin
                want_version = value;
            end else if (idx == CFG_MAX_TEXT_BYTES) begin
                text_cap = value[15:0];
            end
        endfunction

        function void stop_with(t_err code, logic complete);
            t_result r;
            r = '0;
            r.result_kind   = KIND_STATUS;
            r.file_complete = complete;
            r.error_code    = code;
            halted = 1'b1;
            awaited_results.push_back(r);
        endfunction

        function void parse_byte(logic [7:0] b, logic sof, logic eod);
            t_result     r;
            bit          emit;
            bit          word_done;
            logic [15:0] limit;
            r         = '0;
            emit      = 1'b0;
            word_done = 1'b0;
            if (sof) begin
                restart();
            end
            if (halted) begin
                return;
            end
            live_bytes++;
            case (stage)
                PH_MAGIC: begin
                    if (b != SIGNATURE_WORD[8*byte_pos +: 8]) begin
                        stop_with(ERR_MAGIC, 1'b0);
                        return;
                    end
                    byte_pos++;
                    if (byte_pos == 2'd0) begin
                        stage = PH_VERSION;
                    end
                end
                PH_TEXT: begin
                    limit = text_cap - 16'd1;
                    if (text_len == limit) begin
                        stop_with(ERR_LONG, 1'b0);
                        return;
                    end
                    r.result_kind     = KIND_TEXT;
                    r.resource_number = cur_resource;
                    r.language_id     = cur_language;
                    r.text_byte       = b;
                    r.end_of_text     = (b == 8'd0);
                    r.error_code      = ERR_NONE;
                    emit = 1'b1;
                    if (b == 8'd0) begin
                        records_left--;
                        text_len = 16'd0;
                        if (records_left == 31'd0) begin
                            halted = 1'b1;
                            r.file_complete = 1'b1;
                        end else begin
                            stage = PH_RESNUM;
                        end
                    end else begin
                        text_len++;
                    end
                end
                default: begin
                    shift_word = {b, shift_word[31:8]};
                    byte_pos++;
                    word_done = (byte_pos == 2'd0);
                end
            endcase
            if (word_done) begin
                case (stage)
                    PH_VERSION: begin
                        if (shift_word != want_version) begin
                            stop_with(ERR_VERSION, 1'b0);
                            return;
                        end
                        stage = PH_COUNT;
                    end
                    PH_COUNT: begin
                        if (shift_word[31]) begin
                            stop_with(ERR_COUNT, 1'b0);
                            return;
                        end
                        records_left = shift_word[30:0];
                        if (records_left == 31'd0) begin
                            stop_with(ERR_NONE, 1'b1);
                            return;
                        end
                        stage = PH_RESNUM;
                    end
                    PH_RESNUM: begin
                        cur_resource = shift_word;
                        stage = PH_LANG;
                    end
                    default: begin
                        cur_language = shift_word;
                        text_len = 16'd0;
                        stage = PH_TEXT;
                    end
                endcase
            end
            if (eod && !halted) begin
                stop_with(ERR_TRUNC, 1'b0);
                return;
            end
            if (emit) begin
                awaited_results.push_back(r);
            end
        endfunction

        function string show(t_result r);
            return $sformatf("kind=%0d res=%h lang=%h byte=%h eot=%0d done=%0d err=%0d",
                             r.result_kind, r.resource_number, r.language_id,
                             r.text_byte, r.end_of_text, r.file_complete, r.error_code);
        endfunction

        function void report(string what, t_result want, t_result got);
            failures++;
            if (failures <= 10) begin
                $display("%s at %0t: expected %s, got %s", what, $time, show(want), show(got));
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_kind !== want.result_kind ||
                got.resource_number !== want.resource_number ||
                got.language_id !== want.language_id ||
                got.text_byte !== want.text_byte ||
                got.end_of_text !== want.end_of_text ||
                got.file_complete !== want.file_complete ||
                got.error_code !== want.error_code) begin
                report("result mismatch", want, got);
            end
        endfunction

        function void flush_leftovers();
            while (awaited_results.size() != 0) begin
                report("missing result", awaited_results.pop_front(), '0);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_data_byte;
    logic               i_start_of_file;
    logic               i_end_of_data;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_result_kind;
    logic signed [31:0] o_resource_number;
    logic signed [31:0] o_language_id;
    logic [7:0]         o_text_byte;
    logic               o_end_of_text;
    logic               o_file_complete;
    logic [2:0]         o_error_code;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    rrsp_scoreboard sb;
    logic [7:0]     file_bytes[$];
    logic [31:0]    cfg_version;
    logic [15:0]    cfg_cap;
    int             idle_pct;
    int             stall_pct;
    int             hold_request;
    int             hold_left;
    int             cycle_count;

    resource_record_stream_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_start_of_file   (i_start_of_file),
        .i_end_of_data     (i_end_of_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_resource_number (o_resource_number),
        .o_language_id     (o_language_id),
        .o_text_byte       (o_text_byte),
        .o_end_of_text     (o_end_of_text),
        .o_file_complete   (o_file_complete),
        .o_error_code      (o_error_code),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen.result_kind     = o_result_kind;
                seen.resource_number = o_resource_number;
                seen.language_id     = o_language_id;
                seen.text_byte       = o_text_byte;
                seen.end_of_text     = o_end_of_text;
                seen.file_complete   = o_file_complete;
                seen.error_code      = t_err'(o_error_code);
                sb.check_result(seen);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.parse_byte(i_data_byte, i_start_of_file, i_end_of_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("resource_record_stream_parser verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            file_bytes.push_back(w[8*i +: 8]);
        end
    endfunction

    function automatic void push_header(input logic [31:0] ver, input logic [31:0] count);
        push_word(SIGNATURE_WORD);
        push_word(ver);
        push_word(count);
    endfunction

    function automatic void push_record(input logic [31:0] res, input logic [31:0] lang,
                                        input int len);
        push_word(res);
        push_word(lang);
        repeat (len) file_bytes.push_back(8'($urandom_range(1, 255)));
        file_bytes.push_back(8'h00);
    endfunction

    function automatic void push_good_file();
        int count;
        int len;
        count = $urandom_range(1, 4);
        push_header(cfg_version, count);
        repeat (count) begin
            if (cfg_cap <= 16) begin
                len = $urandom_range(cfg_cap);
            end else if ($urandom_range(29) == 0) begin
                len = $urandom_range(60);
            end else begin
                len = $urandom_range(12);
            end
            push_record(rand_word(), rand_word(), len);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic sof, input logic eod);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_data_byte     = b;
        i_start_of_file = sof;
        i_end_of_data   = eod;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_file(input bit with_sof, input bit with_eod);
        int last;
        last = file_bytes.size() - 1;
        for (int i = 0; i <= last; i++) begin
            send_byte(file_bytes[i], with_sof && i == 0, with_eod && i == last);
        end
        file_bytes.delete();
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [31:0] ver, input logic [15:0] cap);
        settle();
        write_reg(CFG_EXPECTED_VERSION, ver);
        write_reg(CFG_MAX_TEXT_BYTES, {16'($urandom), cap});
        cfg_version = ver;
        cfg_cap     = cap;
    endtask

    initial begin
        int  kind;
        int  n;
        int  goal;
        bit  sof;
        bit  eod;
        bit  paused;
        sb              = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = 8'h00;
        i_start_of_file = 1'b0;
        i_end_of_data   = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_EXPECTED_VERSION;
        i_cfg_data      = 32'd0;
        cfg_version     = EXPECTED_VERSION_RESET;
        cfg_cap         = MAX_TEXT_BYTES_RESET;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_request    = 0;
        hold_left       = 0;
        cycle_count     = 0;
        paused          = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h52);
        send_file(1'b1, 1'b0);
        file_bytes.push_back(8'h52);
        file_bytes.push_back(8'h53);
        file_bytes.push_back(8'h43);
        file_bytes.push_back(8'hFF);
        send_file(1'b1, 1'b0);
        push_header(32'd6, 32'd1);
        send_file(1'b1, 1'b0);
        push_header(32'd5, 32'h8000_0000);
        send_file(1'b1, 1'b0);
        push_header(32'd5, 32'd0);
        file_bytes.push_back(8'hAB);
        file_bytes.push_back(8'h00);
        send_file(1'b1, 1'b1);
        push_header(32'd5, 32'd1);
        push_record(32'h7FFF_FFFF, 32'h8000_0000, 2);
        send_file(1'b1, 1'b1);
        file_bytes.push_back(8'h52);
        send_file(1'b0, 1'b0);
        push_header(32'd5, 32'h7FFF_FFFF);
        push_record(32'hFFFF_FFFF, 32'd0, 3);
        void'(file_bytes.pop_back());
        send_file(1'b1, 1'b1);
        file_bytes.push_back(8'h52);
        file_bytes.push_back(8'h53);
        send_file(1'b1, 1'b1);
        push_header(32'd5, 32'd2);
        push_record(32'd0, 32'hFFFF_FFFF, 4);
        push_record(32'h8000_0000, 32'd7, 0);
        send_file(1'b1, 1'b0);

        configure(32'd0, 16'd2);
        push_header(32'd0, 32'd2);
        push_record(32'd1, 32'd2, 0);
        push_record(32'd3, 32'd4, 1);
        send_file(1'b1, 1'b0);
        configure(32'hFFFF_FFFF, 16'd1);
        push_header(32'hFFFF_FFFF, 32'd1);
        push_record(32'd5, 32'd6, 0);
        send_file(1'b1, 1'b1);
        configure(32'hFFFF_FFFF, 16'd0);
        push_header(32'hFFFF_FFFF, 32'd1);
        push_record(32'd7, 32'd8, 5);
        send_file(1'b1, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(32'hFFFF_FFFF, 16'd65535);
                1: configure(32'd0, 16'd2);
                2: configure($urandom, 16'd12);
                default: configure(EXPECTED_VERSION_RESET, MAX_TEXT_BYTES_RESET);
            endcase
            idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 33 : 0;
            stall_pct = (ph == 2) ? 62 : (ph == 3) ? 33 : 0;
            if (ph == 2) begin
                hold_request = HOLD_CYCLES;
            end
            goal = sb.live_bytes + PHASE_BYTES;
            while (sb.live_bytes < goal) begin
                if (ph == 3 && !paused && sb.live_bytes >= goal - PHASE_BYTES / 2) begin
                    settle();
                    paused = 1'b1;
                end
                kind = $urandom_range(99);
                sof  = 1'b1;
                eod  = $urandom_range(1);
                if (kind >= 97) begin
                    n = $urandom_range(1, 8);
                    repeat (n) file_bytes.push_back(8'($urandom));
                    sof = $urandom_range(1);
                end else if (kind >= 93) begin
                    push_good_file();
                    sof = 1'b0;
                end else if (kind >= 88) begin
                    push_good_file();
                    repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom));
                end else if (kind >= 78) begin
                    push_good_file();
                    n = $urandom_range(1, file_bytes.size() - 1);
                    while (file_bytes.size() > n) void'(file_bytes.pop_back());
                    eod = 1'b1;
                end else if (kind >= 74) begin
                    push_header(cfg_version, 32'd0);
                    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
                end else if (kind >= 70) begin
                    push_header(cfg_version, {1'b1, 31'($urandom)});
                end else if (kind >= 65) begin
                    push_header(cfg_version ^ (32'd1 << $urandom_range(31)), 32'd1);
                    push_record(rand_word(), rand_word(), 2);
                end else if (kind >= 60) begin
                    push_good_file();
                    n = $urandom_range(3);
                    file_bytes[n] = file_bytes[n] ^ 8'($urandom_range(1, 255));
                end else begin
                    push_good_file();
                end
                send_file(sof, eod);
            end
        end

        settle();
        sb.flush_leftovers();
        if (sb.failures == 0) begin
            $display("resource_record_stream_parser verification clean");
        end else begin
            $display("resource_record_stream_parser verification failed");
        end
        $finish;
    end

endmodule
